// File: design/bffd_pkg.sv
package bffd_pkg;

  localparam int GRID_COLS = 4;
  localparam int GRID_ROWS = 4;
  localparam int SPACE_DIMS = 2;
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int CELL_W = $clog2(CELLS);
  localparam int DEG_MAX = ((GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS) - 1;
  localparam int DEG_W = $clog2(DEG_MAX + 1);
  localparam int BIN_W = 13;
  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_X_ORIGIN = 2'd0;
  localparam logic [1:0] REG_Y_ORIGIN = 2'd1;
  localparam logic [1:0] REG_X_EXTENT = 2'd2;
  localparam logic [1:0] REG_Y_EXTENT = 2'd3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_DEFORM = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_POW,
    ST_WGT,
    ST_CW,
    ST_SX,
    ST_SY,
    ST_TX,
    ST_TY,
    ST_ACC
  } state_t;

  typedef logic [DEG_MAX:0][BIN_W-1:0] bin_row_t;

  function automatic bin_row_t pascal_row(input int n);
    bin_row_t r;
    r = '0;
    r[0] = BIN_W'(1);
    for (int k = 1; k <= n; k++) begin
      for (int j = k; j >= 1; j--) begin
        r[j] = r[j] + r[j-1];
      end
    end
    return r;
  endfunction

  localparam bin_row_t BIN_X = pascal_row(GRID_COLS - 1);
  localparam bin_row_t BIN_Y = pascal_row(GRID_ROWS - 1);

endpackage

// File: design/bezier_ffd_point_deform_top.sv
// Channel   Direction  Handshake                   Payload
// input     in         start high while busy low    func grid_row grid_col shift_x shift_y
//                                                  point_x point_y
// result    out        done high for one cycle     deformed_x deformed_y
// config    in/out     APB, pready always high     paddr pwdata prdata
//
// A write item completes in the cycle it is accepted and never raises busy.
// A deform item keeps busy high through the bit-serial divide of both axes, then per axis
// through the power and weight steps, then per grid cell through the CW, SX, SY, TX, TY and
// ACC steps, all on the single shared multiplier. The receiver cannot stall.
// Reset clears the origins, the displacement table and the sequencer and sets extents to 65536.
module bezier_ffd_point_deform_top
  import bffd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               func,
  input  logic [3:0]         grid_row,
  input  logic [3:0]         grid_col,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  output logic signed [31:0] deformed_x,
  output logic signed [31:0] deformed_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_t state, state_next;

  logic signed [31:0] x_origin, y_origin;
  logic [30:0] x_extent, y_extent;
  logic signed [31:0] shx [CELLS];
  logic signed [31:0] shy [CELLS];

  logic signed [31:0] pxr, pyr;
  logic signed [32:0] dxr, dyr;
  logic [31:0] rem;
  logic [15:0] quo;
  logic [3:0] dcnt;
  logic ax;
  logic [16:0] ux, uy;
  logic [30:0] pa [DEG_MAX+1];
  logic [30:0] pb [DEG_MAX+1];
  logic [30:0] lasta, lastb;
  logic [DEG_W-1:0] pi;
  logic psel_b;
  logic [1:0] ph;
  logic [31:0] wx [GRID_COLS];
  logic [31:0] wy [GRID_ROWS];
  logic [COL_W-1:0] cc;
  logic [ROW_W-1:0] rr;
  logic [30:0] wreg, sxr, syr;
  logic signed [55:0] accx, accy;
  logic signed [65:0] prod;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] r30, tt;
  logic [35:0] rnd;
  logic signed [55:0] term;
  logic [16:0] ua;
  logic [30:0] a_val, b_val, wc;
  logic [DEG_W-1:0] deg;
  logic [30:0] ext_cur;
  logic signed [32:0] d_cur;
  logic [32:0] r2;
  logic ge;
  logic [31:0] rem_step;
  logic [16:0] u_div;
  logic [CELL_W-1:0] idx;
  logic last_cell;
  logic [BIN_W-1:0] bin;
  logic cfg_wr, wr_hit;
  logic signed [55:0] accy_new, sum_x, sum_y;

  function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
    if (v > 56'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -56'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_X_ORIGIN: prdata = x_origin;
      REG_Y_ORIGIN: prdata = y_origin;
      REG_X_EXTENT: prdata = {1'b0, x_extent};
      REG_Y_EXTENT: prdata = {1'b0, y_extent};
      default:      prdata = '0;
    endcase
  end

  assign r30 = prod + 66'sd536870912;
  assign rnd = r30[65:30];
  assign tt = prod + 66'sd32768;
  assign term = 56'($signed(tt[65:16]));
  assign ua = ax ? uy : ux;
  assign a_val = {ua, 14'b0};
  assign b_val = 31'h40000000 - a_val;
  assign wc = (rnd > 36'h40000000) ? 31'h40000000 : rnd[30:0];
  assign deg = ax ? DEG_W'(GRID_ROWS - 1) : DEG_W'(GRID_COLS - 1);
  assign ext_cur = ax ? y_extent : x_extent;
  assign d_cur = ax ? dyr : dxr;
  assign r2 = {rem, 1'b0};
  assign ge = r2 >= {2'b0, ext_cur};
  assign rem_step = ge ? 32'(r2 - {2'b0, ext_cur}) : r2[31:0];
  assign bin = ax ? BIN_Y[pi] : BIN_X[pi];
  assign idx = CELL_W'(rr) * CELL_W'(GRID_COLS) + CELL_W'(cc);
  assign last_cell = (cc == COL_W'(GRID_COLS - 1)) && (rr == ROW_W'(GRID_ROWS - 1));
  assign accy_new = accy + term;
  assign sum_x = accx + 56'(pxr);
  assign sum_y = accy_new + 56'(pyr);
  assign wr_hit = ({1'b0, grid_row} < 5'(GRID_ROWS)) && ({1'b0, grid_col} < 5'(GRID_COLS));

  always_comb begin
    if ((ext_cur == '0) || (d_cur <= 33'sd0)) begin
      u_div = '0;
    end else if (d_cur >= $signed({2'b0, ext_cur})) begin
      u_div = 17'h10000;
    end else begin
      u_div = {1'b0, quo[14:0], ge};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start && func == FUNC_DEFORM) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt == 4'd15 && ax) begin
          state_next = ST_POW;
        end
      end
      ST_POW: begin
        if (ph == 2'd1 && psel_b && pi == deg) begin
          state_next = ST_WGT;
        end
      end
      ST_WGT: begin
        if (ph == 2'd2 && pi == deg) begin
          state_next = ax ? ST_CW : ST_POW;
        end
      end
      ST_CW:  state_next = ST_SX;
      ST_SX:  state_next = ST_SY;
      ST_SY:  state_next = ST_TX;
      ST_TX:  state_next = ST_TY;
      ST_TY:  state_next = ST_ACC;
      ST_ACC: state_next = last_cell ? ST_IDLE : ST_CW;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = state != ST_IDLE;
    op_a = '0;
    op_b = '0;
    case (state)
      ST_POW: begin
        op_a = psel_b ? {2'b0, lastb} : {2'b0, lasta};
        op_b = psel_b ? {2'b0, b_val} : {2'b0, a_val};
      end
      ST_WGT: begin
        if (ph == 2'd0) begin
          op_a = {2'b0, pb[deg - pi]};
          op_b = {2'b0, pa[pi]};
        end else begin
          op_a = {2'b0, rnd[30:0]};
          op_b = 33'(bin);
        end
      end
      ST_CW: begin
        op_a = {1'b0, wx[cc]};
        op_b = {1'b0, wy[ROW_W'(GRID_ROWS - 1) - rr]};
      end
      ST_SX: begin
        op_a = {2'b0, wc};
        op_b = {2'b0, x_extent};
      end
      ST_SY: begin
        op_a = {2'b0, wreg};
        op_b = {2'b0, y_extent};
      end
      ST_TX: begin
        op_a = {2'b0, sxr};
        op_b = 33'(shx[idx]);
      end
      ST_TY: begin
        op_a = {2'b0, syr};
        op_b = 33'(shy[idx]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      x_origin <= '0;
      y_origin <= '0;
      x_extent <= 31'd65536;
      y_extent <= 31'd65536;
      for (int k = 0; k < CELLS; k++) begin
        shx[k] <= '0;
        shy[k] <= '0;
      end
    end else begin
      state <= state_next;
      done <= (state == ST_ACC) && last_cell;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_X_ORIGIN: x_origin <= pwdata;
          REG_Y_ORIGIN: y_origin <= pwdata;
          REG_X_EXTENT: x_extent <= pwdata[30:0];
          REG_Y_EXTENT: y_extent <= pwdata[30:0];
          default: ;
        endcase
      end
      if (state == ST_IDLE && start && func == FUNC_WRITE && wr_hit) begin
        shx[CELL_W'(grid_row[ROW_W-1:0]) * CELL_W'(GRID_COLS)
            + CELL_W'(grid_col[COL_W-1:0])] <= shift_x;
        shy[CELL_W'(grid_row[ROW_W-1:0]) * CELL_W'(GRID_COLS)
            + CELL_W'(grid_col[COL_W-1:0])] <= shift_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    case (state)
      ST_IDLE: begin
        pxr <= point_x;
        pyr <= point_y;
        dxr <= 33'(point_x) - 33'(x_origin);
        dyr <= 33'(point_y) - 33'(y_origin);
        rem <= 32'(point_x - x_origin);
        quo <= '0;
        dcnt <= '0;
        ax <= 1'b0;
      end
      ST_DIV: begin
        quo <= {quo[14:0], ge};
        dcnt <= dcnt + 4'd1;
        if (dcnt == 4'd15 && !ax) begin
          rem <= dyr[31:0];
        end else begin
          rem <= rem_step;
        end
        if (dcnt == 4'd15) begin
          if (!ax) begin
            ux <= u_div;
            ax <= 1'b1;
          end else begin
            uy <= u_div;
            ax <= 1'b0;
          end
          pa[0] <= 31'h40000000;
          pb[0] <= 31'h40000000;
          lasta <= 31'h40000000;
          lastb <= 31'h40000000;
          pi <= DEG_W'(1);
          psel_b <= 1'b0;
          ph <= 2'd0;
        end
      end
      ST_POW: begin
        if (ph == 2'd0) begin
          ph <= 2'd1;
        end else begin
          ph <= 2'd0;
          if (psel_b) begin
            pb[pi] <= rnd[30:0];
            lastb <= rnd[30:0];
            psel_b <= 1'b0;
            pi <= (pi == deg) ? '0 : pi + DEG_W'(1);
          end else begin
            pa[pi] <= rnd[30:0];
            lasta <= rnd[30:0];
            psel_b <= 1'b1;
          end
        end
      end
      ST_WGT: begin
        if (ph != 2'd2) begin
          ph <= ph + 2'd1;
        end else begin
          ph <= 2'd0;
          if (ax) begin
            wy[pi[ROW_W-1:0]] <= prod[31:0];
          end else begin
            wx[pi[COL_W-1:0]] <= prod[31:0];
          end
          if (pi == deg) begin
            ax <= 1'b1;
            pi <= DEG_W'(1);
            psel_b <= 1'b0;
            lasta <= 31'h40000000;
            lastb <= 31'h40000000;
            cc <= '0;
            rr <= '0;
            accx <= '0;
            accy <= '0;
          end else begin
            pi <= pi + DEG_W'(1);
          end
        end
      end
      ST_SX: wreg <= wc;
      ST_SY: sxr <= rnd[30:0];
      ST_TX: syr <= rnd[30:0];
      ST_TY: accx <= accx + term;
      ST_ACC: begin
        accy <= accy_new;
        if (rr == ROW_W'(GRID_ROWS - 1)) begin
          rr <= '0;
          cc <= cc + COL_W'(1);
        end else begin
          rr <= rr + ROW_W'(1);
        end
        if (last_cell) begin
          deformed_x <= sat32(sum_x);
          deformed_y <= sat32(sum_y);
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a deform in progress");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy still high after the result transfer");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_WRITE) |=> !busy && !done)
    else $error("table write raised busy or a result");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_DEFORM) |=> busy)
    else $error("deform transfer did not start the sequencer");

endmodule

// File: test/tb_bezier_ffd_point_deform_top.sv
module tb_bezier_ffd_point_deform_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bffd_pkg::*;

  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned HALF30 = 64'd1 << 29;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic        func;
    logic [3:0]  grid_row;
    logic [3:0]  grid_col;
    logic [31:0] shift_x;
    logic [31:0] shift_y;
    logic [31:0] point_x;
    logic [31:0] point_y;
  } ffd_item_t;

  typedef struct {
    logic [31:0] dx;
    logic [31:0] dy;
  } ffd_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic func = 1'b0;
  logic [3:0] grid_row = '0;
  logic [3:0] grid_col = '0;
  logic signed [31:0] shift_x = '0;
  logic signed [31:0] shift_y = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] deformed_x, deformed_y;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bezier_ffd_point_deform_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .func(func), .grid_row(grid_row), .grid_col(grid_col),
    .shift_x(shift_x), .shift_y(shift_y), .point_x(point_x), .point_y(point_y),
    .deformed_x(deformed_x), .deformed_y(deformed_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  ffd_item_t pending_items[$];
  ffd_point_t expected_points[$];
  ffd_item_t driven_item;

  longint model_x_origin, model_y_origin;
  longint unsigned model_x_extent, model_y_extent;
  int model_shift_x[CELLS];
  int model_shift_y[CELLS];

  int gap_left = 0;
  bit idle_enabled = 1'b1;
  bit in_taken = 1'b0;
  int mismatches = 0;
  int deforms_checked = 0;
  int writes_sent = 0;
  int cycles = 0;

  function automatic longint unsigned mul_q30(longint unsigned p, longint unsigned q);
    return (p * q + HALF30) >> 30;
  endfunction

  function automatic longint unsigned unit_coord(longint p, longint org,
                                                 longint unsigned ext);
    longint d;
    d = p - org;
    if (ext == 0 || d <= 0) return 0;
    if (longint'(ext) <= d) return 65536;
    return (longint'(d) << 16) / ext;
  endfunction

  function automatic void bernstein_weights(longint unsigned u, int cnt,
                                            output longint unsigned w[16]);
    longint unsigned pa[16], pb[16];
    longint unsigned a, b, c;
    int n;
    a = u << 14;
    b = ONE30 - a;
    c = 1;
    n = cnt - 1;
    pa[0] = ONE30;
    pb[0] = ONE30;
    for (int i = 1; i <= n; i++) begin
      pa[i] = mul_q30(pa[i-1], a);
      pb[i] = mul_q30(pb[i-1], b);
    end
    for (int i = 0; i < 16; i++) w[i] = 0;
    for (int i = 0; i <= n; i++) begin
      w[i] = c * mul_q30(pb[n-i], pa[i]);
      c = c * longint'(n - i) / longint'(i + 1);
    end
  endfunction

  function automatic logic [31:0] saturate32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic ffd_point_t deform_point(ffd_item_t it);
    longint unsigned wx[16], wy[16];
    longint unsigned w, sx, sy;
    longint px, py, sumx, sumy;
    int idx;
    ffd_point_t res;
    px = longint'(signed'(it.point_x));
    py = longint'(signed'(it.point_y));
    sumx = 0;
    sumy = 0;
    bernstein_weights(unit_coord(px, model_x_origin, model_x_extent), GRID_COLS, wx);
    bernstein_weights(unit_coord(py, model_y_origin, model_y_extent), GRID_ROWS, wy);
    for (int c = 0; c < GRID_COLS; c++) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        w = mul_q30(wx[c], wy[GRID_ROWS-1-r]);
        if (w > ONE30) w = ONE30;
        idx = r * GRID_COLS + c;
        sx = (w * model_x_extent + HALF30) >> 30;
        sy = (w * model_y_extent + HALF30) >> 30;
        sumx += (longint'(sx) * longint'(model_shift_x[idx]) + 32768) >>> 16;
        sumy += (longint'(sy) * longint'(model_shift_y[idx]) + 32768) >>> 16;
      end
    end
    res.dx = saturate32(px + sumx);
    res.dy = saturate32(py + sumy);
    return res;
  endfunction

  // Accepted items update the table copy or queue the expected point.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
    if (!rst && start && !busy) begin
      in_taken = 1'b1;
      if (driven_item.func == FUNC_WRITE) begin
        writes_sent++;
        if (driven_item.grid_row < GRID_ROWS && driven_item.grid_col < GRID_COLS) begin
          model_shift_x[driven_item.grid_row * GRID_COLS + driven_item.grid_col] =
            driven_item.shift_x;
          model_shift_y[driven_item.grid_row * GRID_COLS + driven_item.grid_col] =
            driven_item.shift_y;
        end
      end else begin
        expected_points.push_back(deform_point(driven_item));
      end
    end
  end

  always @(posedge clk) begin
    ffd_point_t exp_pt;
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h %h", deformed_x, deformed_y);
      end else begin
        exp_pt = expected_points.pop_front();
        deforms_checked++;
        if (exp_pt.dx !== deformed_x || exp_pt.dy !== deformed_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected x=%h y=%h, got x=%h y=%h",
                     exp_pt.dx, exp_pt.dy, deformed_x, deformed_y);
        end
      end
    end
  end

  // Input driver: holds an item until its transfer, then idles a drawn number of cycles.
  always @(negedge clk) begin
    logic next_start;
    ffd_item_t it;
    next_start = 1'b0;
    if (rst) begin
      next_start = 1'b0;
    end else if (start && !in_taken) begin
      next_start = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
    end else if (pending_items.size() != 0) begin
      it = pending_items.pop_front();
      driven_item = it;
      func <= it.func;
      grid_row <= it.grid_row;
      grid_col <= it.grid_col;
      shift_x <= it.shift_x;
      shift_y <= it.shift_y;
      point_x <= it.point_x;
      point_y <= it.point_y;
      next_start = 1'b1;
      if ($urandom_range(0, 49) == 0) idle_enabled = ~idle_enabled;
      gap_left = idle_enabled ? $urandom_range(0, 9) : 0;
    end
    in_taken = 1'b0;
    start <= next_start;
  end

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({index, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_X_ORIGIN: model_x_origin = longint'(signed'(value));
      REG_Y_ORIGIN: model_y_origin = longint'(signed'(value));
      REG_X_EXTENT: model_x_extent = value[30:0];
      REG_Y_EXTENT: model_y_extent = value[30:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || start || expected_points.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  function automatic ffd_item_t write_item(logic [3:0] r, logic [3:0] c,
                                           logic [31:0] sx, logic [31:0] sy);
    ffd_item_t it;
    it = '{FUNC_WRITE, r, c, sx, sy, $urandom(), $urandom()};
    return it;
  endfunction

  function automatic ffd_item_t deform_item(logic [31:0] px, logic [31:0] py);
    ffd_item_t it;
    it = '{FUNC_DEFORM, 4'($urandom()), 4'($urandom()), $urandom(), $urandom(), px, py};
    return it;
  endfunction

  function automatic logic [31:0] rand_shift();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(longint org, longint unsigned ext);
    longint v;
    if ($urandom_range(0, 4) == 0) return $urandom();
    v = org - longint'(ext / 8) + longint'((ext * 5 / 4) * $urandom_range(0, 1000) / 1000);
    return v[31:0];
  endfunction

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back(write_item(4'($urandom()), 4'($urandom()),
                                              rand_shift(), rand_shift()));
        1, 2, 3: pending_items.push_back(write_item(4'($urandom_range(0, GRID_ROWS-1)),
                   4'($urandom_range(0, GRID_COLS-1)), rand_shift(), rand_shift()));
        default: pending_items.push_back(deform_item(
                   rand_coord(model_x_origin, model_x_extent),
                   rand_coord(model_y_origin, model_y_extent)));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    model_x_origin = 0;
    model_y_origin = 0;
    model_x_extent = 65536;
    model_y_extent = 65536;
    for (int i = 0; i < CELLS; i++) begin
      model_shift_x[i] = 0;
      model_shift_y[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    pending_items.push_back(deform_item(32'h0000_8000, 32'h0000_8000));
    for (int r = 0; r < GRID_ROWS; r++)
      for (int c = 0; c < GRID_COLS; c++)
        pending_items.push_back(write_item(4'(r), 4'(c),
          (r + c) % 2 ? 32'h7FFF_FFFF : 32'h8000_0000,
          (r + c) % 2 ? 32'h8000_0000 : 32'h7FFF_FFFF));
    pending_items.push_back(write_item(4'hF, 4'hF, 32'h1234_5678, 32'h9ABC_DEF0));
    pending_items.push_back(write_item(4'd0, 4'hF, 32'h1, 32'h1));
    pending_items.push_back(deform_item(32'h0000_0000, 32'h0000_0000));
    pending_items.push_back(deform_item(32'h0001_0000, 32'h0001_0000));
    pending_items.push_back(deform_item(32'h7FFF_FFFF, 32'h8000_0000));
    pending_items.push_back(deform_item(32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(deform_item(32'h0000_4000, 32'h0000_C000));
    pending_items.push_back(deform_item(32'hFFFF_FFFF, 32'h0000_FFFF));
    wait_idle();
    run_random(380);

    write_reg(REG_X_ORIGIN, 32'hFFF0_0000);
    write_reg(REG_Y_ORIGIN, 32'h0010_0000);
    write_reg(REG_X_EXTENT, 32'h0040_0000);
    write_reg(REG_Y_EXTENT, 32'h0000_8000);
    run_random(380);

    write_reg(REG_X_EXTENT, 32'h0000_0000);
    write_reg(REG_Y_EXTENT, 32'h0000_0000);
    pending_items.push_back(deform_item(32'h0000_0000, 32'h0010_0000));
    run_random(360);

    write_reg(REG_X_ORIGIN, 32'h8000_0000);
    write_reg(REG_Y_ORIGIN, 32'h7FFF_FFFF);
    write_reg(REG_X_EXTENT, 32'h7FFF_FFFF);
    write_reg(REG_Y_EXTENT, 32'hFFFF_FFFF);
    run_random(380);

    write_reg(REG_X_ORIGIN, 32'h0000_0000);
    write_reg(REG_Y_ORIGIN, 32'hFFFF_0000);
    write_reg(REG_X_EXTENT, 32'h0000_0001);
    write_reg(REG_Y_EXTENT, 32'h0002_0000);
    run_random(380);

    $display("Checked %0d deformed points and sent %0d table writes over five box settings.",
             deforms_checked, writes_sent);
    $display("Settings covered zero, unit, smallest and largest extents; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
